FILE: src/bsp_pkg.sv
// bsp_pkg: shared types and constants for the ball sprite position renderer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bsp_pkg;

  localparam int unsigned ModeW    = 4;
  localparam int unsigned ValueW   = 8;
  localparam int unsigned ClockW   = 4;
  localparam int unsigned CollW    = 15;
  localparam int unsigned ColorW   = 8;
  localparam int unsigned PosW     = 8;
  localparam int unsigned WidthW   = 4;
  localparam int unsigned CountW   = 5;

  localparam logic [PosW-1:0]   PosHblank   = 8'd159;
  localparam logic [PosW-1:0]   PosVisible  = 8'd157;
  localparam logic [PosW-1:0]   PosWindow   = 8'd156;
  localparam logic [PosW-1:0]   PosWrap     = 8'd160;
  localparam logic signed [CountW-1:0] CountStart = -5'sd4;
  localparam logic [ClockW-1:0] MotionFlip  = 4'h8;
  localparam logic [WidthW-1:0] WidthReset  = 4'd1;

  typedef enum logic [ModeW-1:0] {
    ModeEnable    = 4'd0,
    ModeMotion    = 4'd1,
    ModeResetPos  = 4'd2,
    ModeWidth     = 4'd3,
    ModeVdelay    = 4'd4,
    ModeColor     = 4'd5,
    ModeStartMove = 4'd6,
    ModeMoveTick  = 4'd7,
    ModeRender    = 4'd8,
    ModeTick      = 4'd9,
    ModeShuffle   = 4'd10
  } bsp_mode_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [ValueW-1:0] value;
    logic              hblank;
    logic [ClockW-1:0] move_clock;
    logic              apply;
  } bsp_item_t;

  typedef struct packed {
    logic [CollW-1:0]  collision;
    logic              moving;
    logic [ColorW-1:0] color;
  } bsp_result_t;

endpackage

`default_nettype wire

FILE: src/ball_sprite_position_renderer.sv
// ball_sprite_position_renderer: top level with input register, mask register and result valid
// depends on bsp_pkg and bsp_core
`timescale 1ns / 1ps
`default_nettype none

// Ball sprite of a video chip, driven one event word per pixel clock unless
// stalled. Each accepted input word (register write, motion, render, tick or
// shuffle event chosen by mode_i) produces exactly one result word carrying
// the collision word, the moving flag and the ball color after that event. A
// new word can be accepted every cycle while in_stall_o is low; the input
// register loads it and the result is valid once the bsp_core state update
// loads it, which out_stall_i can hold back. The user must write collision_mask
// through cfg_we_i / cfg_wdata_i only while the block is idle; the block itself
// does not enforce this. The mask takes effect at the next render event.
module ball_sprite_position_renderer
  import bsp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CollW-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ModeW-1:0]  mode_i,
  input  wire logic [ValueW-1:0] value_i,
  input  wire logic              hblank_i,
  input  wire logic [ClockW-1:0] move_clock_i,
  input  wire logic              apply_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CollW-1:0]       collision_o,
  output logic                   moving_o,
  output logic [ColorW-1:0]      color_o
);

  logic [CollW-1:0] mask_q;
  logic             s1_valid_q, s1_valid_d;
  bsp_item_t        s1_item_q;
  logic             out_valid_q, out_valid_d;
  logic             step;
  logic             in_take;
  bsp_result_t      result;

  assign step       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_take || (s1_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.mode       <= mode_i;
      s1_item_q.value      <= value_i;
      s1_item_q.hblank     <= hblank_i;
      s1_item_q.move_clock <= move_clock_i;
      s1_item_q.apply      <= apply_i;
    end
  end

  bsp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (s1_item_q),
    .mask_i   (mask_q),
    .result_o (result)
  );

  assign out_valid_o = out_valid_q;
  assign collision_o = result.collision;
  assign moving_o    = result.moving;
  assign color_o     = result.color;

endmodule

`default_nettype wire

FILE: src/bsp_core.sv
// bsp_core: ball state registers and the combinational event update
// depends on bsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsp_core
  import bsp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire bsp_item_t        item_i,
  input  wire logic [CollW-1:0] mask_i,
  output bsp_result_t           result_o
);

  logic [ColorW-1:0]        color_q, color_d;
  logic [CollW-1:0]         coll_q, coll_d;
  logic                     en_old_q, en_old_d;
  logic                     en_new_q, en_new_d;
  logic                     delaying_q, delaying_d;
  logic [ClockW-1:0]        motion_q, motion_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic                     moving_q, moving_d;
  logic [WidthW-1:0]        width_q, width_d;
  logic                     rendering_q, rendering_d;
  logic signed [CountW-1:0] count_q, count_d;

  logic                     en_eff;
  logic                     draw;
  logic                     do_render;
  logic                     do_tick;
  logic signed [CountW-1:0] count_inc;
  logic [PosW-1:0]          pos_inc;

  assign en_eff    = delaying_q ? en_old_q : en_new_q;
  assign draw      = rendering_q && (count_q >= 0) && en_eff;
  assign count_inc = count_q + 5'sd1;
  assign pos_inc   = pos_q + 8'd1;

  always_comb begin
    color_d     = color_q;
    coll_d      = coll_q;
    en_old_d    = en_old_q;
    en_new_d    = en_new_q;
    delaying_d  = delaying_q;
    motion_d    = motion_q;
    pos_d       = pos_q;
    moving_d    = moving_q;
    width_d     = width_q;
    rendering_d = rendering_q;
    count_d     = count_q;
    do_render   = 1'b0;
    do_tick     = 1'b0;

    unique case (bsp_mode_e'(item_i.mode))
      ModeEnable:    en_new_d = item_i.value[1];
      ModeMotion:    motion_d = item_i.value[7:4] ^ MotionFlip;
      ModeResetPos: begin
        pos_d = item_i.hblank ? PosHblank : PosVisible;
        if (!item_i.hblank) begin
          rendering_d = 1'b1;
          count_d     = CountStart;
        end
      end
      ModeWidth:     width_d = WidthW'(WidthReset << item_i.value[5:4]);
      ModeVdelay:    delaying_d = item_i.value[0];
      ModeColor:     color_d = item_i.value;
      ModeStartMove: moving_d = 1'b1;
      ModeMoveTick: begin
        if (item_i.move_clock == motion_q) begin
          moving_d = 1'b0;
        end
        if (moving_d && item_i.apply) begin
          do_render = 1'b1;
          do_tick   = 1'b1;
        end
      end
      ModeRender:    do_render = 1'b1;
      ModeTick:      do_tick = 1'b1;
      ModeShuffle:   en_old_d = en_new_q;
      default: ;
    endcase

    if (do_render) begin
      coll_d = draw ? '0 : mask_i;
    end

    if (do_tick) begin
      if (pos_q == PosWindow) begin
        rendering_d = 1'b1;
        count_d     = CountStart;
      end else if (rendering_q) begin
        count_d = count_inc;
        if (count_inc >= $signed({1'b0, width_q})) begin
          rendering_d = 1'b0;
        end
      end
      pos_d = (pos_inc >= PosWrap) ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= '0;
      coll_q      <= '0;
      en_old_q    <= 1'b0;
      en_new_q    <= 1'b0;
      delaying_q  <= 1'b0;
      motion_q    <= '0;
      pos_q       <= '0;
      moving_q    <= 1'b0;
      width_q     <= WidthReset;
      rendering_q <= 1'b0;
      count_q     <= '0;
    end else if (step_i) begin
      color_q     <= color_d;
      coll_q      <= coll_d;
      en_old_q    <= en_old_d;
      en_new_q    <= en_new_d;
      delaying_q  <= delaying_d;
      motion_q    <= motion_d;
      pos_q       <= pos_d;
      moving_q    <= moving_d;
      width_q     <= width_d;
      rendering_q <= rendering_d;
      count_q     <= count_d;
    end
  end

  assign result_o.collision = coll_q;
  assign result_o.moving    = moving_q;
  assign result_o.color     = color_q;

endmodule

`default_nettype wire
